// ----- design/bfpe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfpe_pkg - shared types and constants of the bitmap framebuffer pixel engine
// Action and status codes, byte constants and the RAM control group.
// ----------------------------------------------------------------------------
package bfpe_pkg;

    localparam int BYTE_W      = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
    localparam logic [2:0]        BIT_MSB   = 3'd7;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_START    = 2'd1,
        ST_END      = 2'd2,
        ST_REVERSED = 2'd3
    } t_status;

    // per-plane RAM strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ram_ctl;

endpackage : bfpe_pkg
`default_nettype wire

// ----- design/bfpe_plane_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfpe_plane_ram - single-port byte RAM for one bitmap plane
// Registered read; write and read share the address.
// ----------------------------------------------------------------------------
module bfpe_plane_ram #(
    parameter int DEPTH = 5000,
    parameter int AW    = 13
) (
    input  wire                      i_clk,
    input  bfpe_pkg::t_ram_ctl       i_ctl,
    input  wire  [AW-1:0]            i_addr,
    input  wire  [bfpe_pkg::BYTE_W-1:0] i_wdata,
    output logic [bfpe_pkg::BYTE_W-1:0] o_rdata
);
    import bfpe_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule : bfpe_plane_ram
`default_nettype wire

// ----- design/bitmap_framebuffer_pixel_engine_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_framebuffer_pixel_engine_top - two-plane 1bpp framebuffer engine
// Pixel write/read, rectangle fill and plane clear on black and red planes.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready action, plane, coords, ink
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready status, pixel
//
// Sequence: a point write/read reads its byte when accepted, then one RAM
// read-modify-write step follows; a rejected item goes to the hold state.
// A fill walks the bytes it touches (each byte is read then written on the single RAM port).
// A clear fills its plane with 0xFF, one byte written per cycle.
// Reset: a clearing pass over all PLANE_BYTES addresses (5000 at 200x200)
// writes 0xFF into both planes; no item is accepted until it ends.
// Stalls: one item at a time; the result register frees the input side, but
// a finished result waits in a hold state while the previous one is unread.
//
// Bitmap layout: row y is stored in row PANEL_HEIGHT-1-y, ROW_BYTES per row,
// MSB is the leftmost pixel, a cleared bit is inked.
// ----------------------------------------------------------------------------
module bitmap_framebuffer_pixel_engine_top #(
    parameter int PANEL_WIDTH  = 200,
    parameter int PANEL_HEIGHT = 200
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [1:0] action, [2] plane, [10:3] x_coord, [18:11] y_coord,
    // [26:19] x_end, [34:27] y_end, [35] ink, [39:36] zero
    input  wire  [bfpe_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // [1:0] status, [2] pixel, [7:3] zero
    output logic [bfpe_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import bfpe_pkg::*;

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int PLANE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW          = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PLANE_BYTES - 1);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_POINT, S_FRD, S_FWR, S_SWEEP, S_HOLD
    } t_state;

    // flipped row and byte column to byte address
    function automatic logic [AW-1:0] f_addr(input logic [7:0] row,
                                             input logic [4:0] col);
        logic [15:0] a;
        a = (16'(PANEL_HEIGHT - 1) - {8'd0, row}) * 16'(ROW_BYTES)
            + {11'd0, col};
        return a[AW-1:0];
    endfunction

    // input item fields
    t_action    in_action;
    logic       in_plane;
    logic [7:0] in_x, in_y, in_xe, in_ye;
    logic       in_ink;
    logic       start_ok, end_ok;

    assign in_action = t_action'(i_s_axis_tdata[1:0]);
    assign in_plane  = i_s_axis_tdata[2];
    assign in_x      = i_s_axis_tdata[10:3];
    assign in_y      = i_s_axis_tdata[18:11];
    assign in_xe     = i_s_axis_tdata[26:19];
    assign in_ye     = i_s_axis_tdata[34:27];
    assign in_ink    = i_s_axis_tdata[35];
    assign start_ok  = ({1'b0, in_x} < 9'(PANEL_WIDTH)) && ({1'b0, in_y} < 9'(PANEL_HEIGHT));
    assign end_ok    = ({1'b0, in_xe} < 9'(PANEL_WIDTH)) && ({1'b0, in_ye} < 9'(PANEL_HEIGHT));

    // registers
    t_state          r_state, n_state;
    t_action         r_action, n_action;
    logic            r_plane, n_plane;
    logic            r_ink, n_ink;
    logic [2:0]      r_xlo, n_xlo;       // first bit offset (or point bit)
    logic [2:0]      r_xhi, n_xhi;       // last bit offset of the fill
    logic [4:0]      r_col, n_col;
    logic [4:0]      r_col_lo, n_col_lo;
    logic [4:0]      r_col_hi, n_col_hi;
    logic [7:0]      r_row, n_row;
    logic [7:0]      r_row_hi, n_row_hi;
    logic [AW-1:0]   r_addr, n_addr;
    t_status         r_res_status, n_res_status;
    logic            r_res_pixel, n_res_pixel;
    logic            r_out_valid, n_out_valid;
    t_status         r_out_status, n_out_status;
    logic            r_out_pixel, n_out_pixel;

    // RAM side
    t_ram_ctl          ctl_blk, ctl_red;
    logic [AW-1:0]     ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] rdata_blk, rdata_red, rbyte;
    logic [BYTE_W-1:0] mask, fill_mask;
    logic [2:0]        lo, hi;
    logic              rd_en, wr_en, wr_both;

    logic    accept, out_free, fin, fin_pixel;
    t_status fin_status;

    assign accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign rbyte    = r_plane ? rdata_red : rdata_blk;

    // bit mask of the pixels of this byte that lie inside the fill
    always_comb begin
        lo = (r_col == r_col_lo) ? r_xlo : 3'd0;
        hi = (r_col == r_col_hi) ? r_xhi : BIT_MSB;
        for (int j = 0; j < 8; j++) begin
            fill_mask[7 - j] = (3'(j) >= lo) && (3'(j) <= hi);
        end
        mask = (r_state == S_POINT) ? (8'h80 >> r_xlo) : fill_mask;
    end

    // RAM address, strobes and write data
    always_comb begin
        ram_addr = r_addr;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_both  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                ram_addr = f_addr(in_y, in_x[7:3]);
                rd_en    = accept && start_ok
                           && (in_action == ACT_WRITE || in_action == ACT_READ);
            end
            S_FRD: begin
                ram_addr = f_addr(r_row, r_col);
                rd_en    = 1'b1;
            end
            S_POINT: wr_en = (r_action == ACT_WRITE);
            S_FWR:   wr_en = 1'b1;
            S_SWEEP: wr_en = 1'b1;
            S_INIT:  wr_both = 1'b1;
            S_HOLD:  ;
            default: ;
        endcase
        if (r_state == S_SWEEP || r_state == S_INIT) begin
            ram_wdata = BYTE_ONES;
        end else if (r_ink) begin
            ram_wdata = rbyte & ~mask;
        end else begin
            ram_wdata = rbyte | mask;
        end
        ctl_blk.rd_en = rd_en && !in_plane;
        ctl_red.rd_en = rd_en && in_plane;
        if (r_state == S_FRD) begin
            ctl_blk.rd_en = !r_plane;
            ctl_red.rd_en = r_plane;
        end
        ctl_blk.wr_en = wr_both || (wr_en && !r_plane);
        ctl_red.wr_en = wr_both || (wr_en && r_plane);
    end

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_plane      = r_plane;
        n_ink        = r_ink;
        n_xlo        = r_xlo;
        n_xhi        = r_xhi;
        n_col        = r_col;
        n_col_lo     = r_col_lo;
        n_col_hi     = r_col_hi;
        n_row        = r_row;
        n_row_hi     = r_row_hi;
        n_addr       = r_addr;
        n_res_status = r_res_status;
        n_res_pixel  = r_res_pixel;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_pixel  = r_out_pixel;
        fin          = 1'b0;
        fin_status   = ST_OK;
        fin_pixel    = 1'b0;

        unique case (r_state)
            S_INIT: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_action     = in_action;
                    n_plane      = in_plane;
                    n_ink        = in_ink;
                    n_xlo        = in_x[2:0];
                    n_xhi        = in_xe[2:0];
                    n_col        = in_x[7:3];
                    n_col_lo     = in_x[7:3];
                    n_col_hi     = in_xe[7:3];
                    n_row        = in_y;
                    n_row_hi     = in_ye;
                    n_addr       = ram_addr;
                    n_res_status = ST_OK;
                    n_res_pixel  = 1'b0;
                    unique case (in_action)
                        ACT_WRITE, ACT_READ: begin
                            if (start_ok) begin
                                n_state = S_POINT;
                            end else begin
                                n_res_status = ST_START;
                                n_state      = S_HOLD;
                            end
                        end
                        ACT_FILL: begin
                            if (!start_ok) begin
                                n_res_status = ST_START;
                                n_state      = S_HOLD;
                            end else if (!end_ok) begin
                                n_res_status = ST_END;
                                n_state      = S_HOLD;
                            end else if (in_x > in_xe || in_y > in_ye) begin
                                n_res_status = ST_REVERSED;
                                n_state      = S_HOLD;
                            end else begin
                                n_state = S_FRD;
                            end
                        end
                        ACT_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_POINT: begin
                fin       = 1'b1;
                fin_pixel = (r_action == ACT_READ) && !rbyte[BIT_MSB - r_xlo];
            end
            S_FRD: begin
                n_addr  = ram_addr;
                n_state = S_FWR;
            end
            S_FWR: begin
                if (r_col == r_col_hi) begin
                    if (r_row == r_row_hi) begin
                        fin = 1'b1;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_col   = r_col_lo;
                        n_state = S_FRD;
                    end
                end else begin
                    n_col   = r_col + 1'b1;
                    n_state = S_FRD;
                end
            end
            S_SWEEP: begin
                if (r_addr == LAST_ADDR) begin
                    fin = 1'b1;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_HOLD: begin
                fin        = 1'b1;
                fin_status = r_res_status;
                fin_pixel  = r_res_pixel;
            end
            default: ;
        endcase

        // hand the result to the output register, or park it
        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = fin_status;
                n_out_pixel  = fin_pixel;
                n_state      = S_IDLE;
            end else begin
                n_res_status = fin_status;
                n_res_pixel  = fin_pixel;
                n_state      = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
        r_action     <= n_action;
        r_plane      <= n_plane;
        r_ink        <= n_ink;
        r_xlo        <= n_xlo;
        r_xhi        <= n_xhi;
        r_col        <= n_col;
        r_col_lo     <= n_col_lo;
        r_col_hi     <= n_col_hi;
        r_row        <= n_row;
        r_row_hi     <= n_row_hi;
        r_res_status <= n_res_status;
        r_res_pixel  <= n_res_pixel;
        r_out_status <= n_out_status;
        r_out_pixel  <= n_out_pixel;
    end

    bfpe_plane_ram #(.DEPTH(PLANE_BYTES), .AW(AW)) u_black_ram (
        .i_clk   (i_clk),
        .i_ctl   (ctl_blk),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rdata_blk)
    );

    bfpe_plane_ram #(.DEPTH(PLANE_BYTES), .AW(AW)) u_red_ram (
        .i_clk   (i_clk),
        .i_ctl   (ctl_red),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rdata_red)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_pixel, r_out_status};

`ifndef ASSERT_OFF
    // single port: never read and write a plane in the same cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl_blk.rd_en && ctl_blk.wr_en) && !(ctl_red.rd_en && ctl_red.wr_en))
        else $error("plane RAM read and write in one cycle");

    // only one plane is touched outside the reset pass
    a_one_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> !(ctl_blk.wr_en && ctl_red.wr_en))
        else $error("both planes written outside reset pass");

    // no item completes in its accept cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("engine idle right after accepting an item");

    // fill walk stays inside the rectangle
    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD) |-> (r_row <= r_row_hi && r_col <= r_col_hi))
        else $error("fill walk left the rectangle");
`endif

endmodule : bitmap_framebuffer_pixel_engine_top
`default_nettype wire
